FILE: sv/fct_pkg.sv
package fct_pkg;

    localparam int TAPS     = 64;
    localparam int ADDR_W   = $clog2(TAPS);
    localparam int CNT_W    = $clog2(TAPS + 1);
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 6;
    localparam int CFG_W    = 7;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + ADDR_W;
    localparam int QSHIFT   = 15;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [APB_AW-1:0] REG_TAP_COUNT  = 3'd0;
    localparam logic [CFG_W-1:0]  TAP_COUNT_RST  = 7'd64;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    typedef struct packed {
        logic clear;
        logic rd_vld;
        logic coef_ok;
        logic samp_ok;
    } mac_ctl_t;

endpackage

FILE: sv/fct_ram.sv
module fct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fct_mac.sv
module fct_mac (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fct_pkg::mac_ctl_t              ctl,
    input  logic [fct_pkg::SAMPLE_W-1:0]   coef,
    input  logic [fct_pkg::SAMPLE_W-1:0]   samp,
    output logic                           busy,
    output logic [fct_pkg::SAMPLE_W-1:0]   result,
    output logic                           sat
);
    import fct_pkg::*;

    localparam int Q_W = ACC_W - QSHIFT;

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_vld_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [Q_W-1:0]      q;
    logic [Q_W-QSHIFT-1:0]      top_bits;

    assign a = ctl.coef_ok ? signed'(coef) : '0;
    assign b = ctl.samp_ok ? signed'(samp) : '0;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= ctl.rd_vld;
            if (ctl.clear) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // floor shift, then clip to 16 bits
    assign q        = Q_W'(acc_reg >>> QSHIFT);
    assign top_bits = q[Q_W-1:QSHIFT];
    assign sat      = !((&top_bits) || !(|top_bits));

    always_comb begin
        if (sat) begin
            result = q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            result = q[SAMPLE_W-1:0];
        end
    end

    assign busy = ctl.rd_vld | prod_vld_reg;

endmodule

FILE: sv/fir_convolution_with_tail_unit.sv
// Direct-form FIR convolution of a Q15 sample stream with a stored impulse response of
// tap_count taps (clamped to 1..64). Input words with tuser 0 load one coefficient; words
// with tuser 1 shift a sample in and produce one result. A sample with tlast set
// is followed by tap_count-1 tail results computed on zeros, after which the delay line is
// empty. Each result is a multiply-accumulate that walks the taps with one coefficient and
// one delay-line read per cycle from two memories, then the pipeline drains and the result
// is loaded into the output register. The input is taken only while no result is in
// progress; a finished result sits in the output register and the next word may be accepted
// meanwhile, while a result that finds the output register still full waits until it is taken.
module fir_convolution_with_tail_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tap_index[5:0], value[21:6], zero pad[23:22]
    input  logic [fct_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // output_sample[15:0]
    output logic [fct_pkg::M_TDATA_W-1:0] m_tdata,
    // saturated
    output logic                          m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fct_pkg::APB_AW-1:0]    paddr,
    input  logic [fct_pkg::APB_DW-1:0]    pwdata,
    output logic [fct_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import fct_pkg::*;

    localparam logic [ADDR_W:0]   TAPS_X = (ADDR_W + 1)'(TAPS);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(TAPS - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  tap_count_reg;
    logic [ADDR_W-1:0] head_reg, head_next, head_inc;
    logic [CNT_W-1:0]  m_reg, m_next, m_use;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic              last_reg, last_next;
    logic [TAPS-1:0]   coef_vld_reg, coef_vld_next;
    logic [TAPS-1:0]   dly_vld_reg, dly_vld_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              coef_ok_reg, coef_ok_next;
    logic              samp_ok_reg, samp_ok_next;

    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;
    logic                    out_load;
    logic                    out_free;
    logic                    out_last;

    logic                    s_acc;
    logic [ADDR_W-1:0]       in_idx;
    logic [SAMPLE_W-1:0]     in_val;
    logic                    clear;
    logic                    re;
    logic [ADDR_W-1:0]       cidx;
    logic [ADDR_W-1:0]       daddr;
    logic                    coef_we;
    logic                    dly_we;
    logic [SAMPLE_W-1:0]     coef_rd;
    logic [SAMPLE_W-1:0]     samp_rd;
    logic                    mac_busy;
    logic [SAMPLE_W-1:0]     mac_result;
    logic                    mac_sat;
    logic                    cfg_wr;
    mac_ctl_t                ctl;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr == REG_TAP_COUNT) ? APB_DW'(tap_count_reg) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign in_idx   = s_tdata[ADDR_W-1:0];
    assign in_val   = s_tdata[IDX_W +: SAMPLE_W];
    assign head_inc = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
    assign cidx     = cnt_reg[ADDR_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_last = last_reg && (tail_reg == m_reg - 1'b1);

    always_comb begin
        if (tap_count_reg == '0) begin
            m_use = CNT_W'(1);
        end else if (tap_count_reg > CFG_W'(TAPS)) begin
            m_use = CNT_W'(TAPS);
        end else begin
            m_use = CNT_W'(tap_count_reg);
        end
    end

    always_comb begin
        if (head_reg >= cidx) begin
            daddr = head_reg - cidx;
        end else begin
            daddr = ADDR_W'({1'b0, head_reg} + TAPS_X - {1'b0, cidx});
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        m_next        = m_reg;
        cnt_next      = cnt_reg;
        tail_next     = tail_reg;
        last_next     = last_reg;
        coef_vld_next = coef_vld_reg;
        dly_vld_next  = dly_vld_reg;
        rd_vld_next   = 1'b0;
        coef_ok_next  = coef_ok_reg;
        samp_ok_next  = samp_ok_reg;
        coef_we       = 1'b0;
        dly_we        = 1'b0;
        re            = 1'b0;
        clear         = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == KIND_LOAD) begin
                        if ({1'b0, s_tdata[IDX_W-1:0]} < TAPS_X) begin
                            coef_we               = 1'b1;
                            coef_vld_next[in_idx] = 1'b1;
                        end
                    end else begin
                        dly_we                 = 1'b1;
                        head_next              = head_inc;
                        dly_vld_next[head_inc] = 1'b1;
                        m_next                 = m_use;
                        last_next              = s_tlast;
                        tail_next              = '0;
                        cnt_next               = '0;
                        clear                  = 1'b1;
                        state_next             = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                re           = 1'b1;
                rd_vld_next  = 1'b1;
                coef_ok_next = coef_vld_reg[cidx];
                samp_ok_next = dly_vld_reg[daddr];
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == m_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_reg && !out_last) begin
                        // tail: shift a zero in
                        tail_next              = tail_reg + 1'b1;
                        head_next              = head_inc;
                        dly_vld_next[head_inc] = 1'b0;
                        cnt_next               = '0;
                        clear                  = 1'b1;
                        state_next             = ST_MAC;
                    end else begin
                        if (last_reg) begin
                            dly_vld_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RST;
            head_reg      <= '0;
            m_reg         <= CNT_W'(1);
            cnt_reg       <= '0;
            tail_reg      <= '0;
            last_reg      <= 1'b0;
            coef_vld_reg  <= '0;
            dly_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            coef_ok_reg   <= 1'b0;
            samp_ok_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            m_reg        <= m_next;
            cnt_reg      <= cnt_next;
            tail_reg     <= tail_next;
            last_reg     <= last_next;
            coef_vld_reg <= coef_vld_next;
            dly_vld_reg  <= dly_vld_next;
            rd_vld_reg   <= rd_vld_next;
            coef_ok_reg  <= coef_ok_next;
            samp_ok_reg  <= samp_ok_next;
            if (cfg_wr && paddr == REG_TAP_COUNT) begin
                tap_count_reg <= pwdata[CFG_W-1:0];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= mac_result;
            m_tuser_reg <= mac_sat;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    fct_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (in_idx),
        .wdata (in_val),
        .re    (re),
        .raddr (cidx),
        .rdata (coef_rd)
    );

    fct_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_dly_ram (
        .aclk  (aclk),
        .we    (dly_we),
        .waddr (head_inc),
        .wdata (in_val),
        .re    (re),
        .raddr (daddr),
        .rdata (samp_rd)
    );

    assign ctl.clear   = clear;
    assign ctl.rd_vld  = rd_vld_reg;
    assign ctl.coef_ok = coef_ok_reg;
    assign ctl.samp_ok = samp_ok_reg;

    fct_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .coef    (coef_rd),
        .samp    (samp_rd),
        .busy    (mac_busy),
        .result  (mac_result),
        .sat     (mac_sat)
    );

    a_sample_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == KIND_SAMPLE) |=> (state_reg == ST_MAC))
        else $error("sample word did not start accumulation");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (cnt_reg < m_reg))
        else $error("tap counter past tap count");

    a_fin_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> !mac_busy)
        else $error("result taken before accumulator settled");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last) |=> (dly_vld_reg == '0))
        else $error("delay line not cleared after final result");

endmodule

FILE: dv/fir_convolution_with_tail_unit_test.sv
`timescale 1ns / 100ps

module fir_convolution_with_tail_unit_test;
    import fct_pkg::*;

    localparam int  LIMIT_CYCLES = 5_000_000;
    localparam int  DRAIN_CYCLES = 2 * TAPS + 16;
    localparam int  RAND_PHASES  = 8;
    localparam int  PHASE_WORDS  = 32;
    localparam int  DIR_STEPS    = 24;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SAMPLE,
        OP_TAPS
    } step_op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sat;
        logic                last;
    } fir_res_t;

    typedef struct packed {
        step_op_t            op;
        logic [IDX_W-1:0]    idx;
        logic [SAMPLE_W-1:0] val;
        logic                last;
        logic                chk;
        fir_res_t            res;
    } dir_step_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = KIND_LOAD;
    logic                 s_tlast  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // fixed result attached to the word on the bus, if any
    logic                 word_chk = 1'b0;
    fir_res_t             word_res = '0;

    logic signed [SAMPLE_W-1:0] delay_taps [TAPS];
    logic signed [SAMPLE_W-1:0] coef_taps  [TAPS];
    logic [CFG_W-1:0]           taps_reg;
    fir_res_t                   conv_q [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_count    = 0;
    int cycle_count  = 0;

    const int tx_mode [4] = '{0, 47, 0, 24};
    const int rx_mode [4] = '{0, 0, 47, 24};

    dir_step_t dir_steps [DIR_STEPS] = '{
        '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{OP_LOAD,   6'd0,  16'h7FFF, 1'b1, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b1, '{16'h8001, 1'b0, 1'b0}},
        '{OP_LOAD,   6'd63, 16'h8000, 1'b0, 1'b0, '0},
        '{OP_LOAD,   6'd1,  16'd12345, 1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'h0000, 1'b1, 1'b0, '0},
        '{OP_TAPS,   6'd0,  16'd1,    1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, '{16'd32766, 1'b0, 1'b1}},
        '{OP_LOAD,   6'd0,  16'h8000, 1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'h8000, 1'b1, 1'b1, '{16'h7FFF, 1'b1, 1'b1}},
        '{OP_SAMPLE, 6'd0,  16'h0001, 1'b0, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{OP_LOAD,   6'd0,  16'h7FFF, 1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b0, 1'b1}},
        '{OP_TAPS,   6'd0,  16'd0,    1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'd16384, 1'b1, 1'b1, '{16'd16383, 1'b0, 1'b1}},
        '{OP_TAPS,   6'd0,  16'd127,  1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd63, 16'h8000, 1'b1, 1'b0, '0},
        '{OP_TAPS,   6'd0,  16'd2,    1'b0, 1'b0, '0},
        '{OP_LOAD,   6'd0,  16'h8000, 1'b0, 1'b0, '0},
        '{OP_LOAD,   6'd1,  16'h8000, 1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, '{16'h8001, 1'b0, 1'b0}},
        '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, '{16'h8000, 1'b1, 1'b0}},
        '{OP_SAMPLE, 6'd0,  16'd100,  1'b0, 1'b0, '0},
        '{OP_SAMPLE, 6'd0,  16'hFF38, 1'b1, 1'b0, '0}
    };

    fir_convolution_with_tail_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int taps_eff(input logic [CFG_W-1:0] t);
        if (t == 0) return 1;
        if (t > TAPS) return TAPS;
        return int'(t);
    endfunction

    function automatic fir_res_t fir_point(input logic last);
        int       m;
        longint   acc;
        longint   q;
        fir_res_t r;
        m   = taps_eff(taps_reg);
        acc = 0;
        for (int i = 0; i < m; i++) acc += longint'(delay_taps[i]) * longint'(coef_taps[i]);
        q     = acc >>> QSHIFT;
        r.sat = 1'b0;
        if (q > 32767) begin
            q     = 32767;
            r.sat = 1'b1;
        end else if (q < -32768) begin
            q     = -32768;
            r.sat = 1'b1;
        end
        r.sample = q[SAMPLE_W-1:0];
        r.last   = last;
        return r;
    endfunction

    task automatic shift_delay(input logic signed [SAMPLE_W-1:0] v);
        for (int i = TAPS - 1; i > 0; i--) delay_taps[i] = delay_taps[i-1];
        delay_taps[0] = v;
    endtask

    // one result per sample, plus the zero-fed tail on a last sample
    task automatic predict_sample(input logic signed [SAMPLE_W-1:0] v, input logic last);
        int m;
        m = taps_eff(taps_reg);
        shift_delay(v);
        conv_q.push_back(fir_point(last && m == 1));
        if (last) begin
            for (int t = 1; t < m; t++) begin
                shift_delay('0);
                conv_q.push_back(fir_point(t == m - 1));
            end
            for (int i = 0; i < TAPS; i++) delay_taps[i] = '0;
        end
    endtask

    task automatic flag_mismatch(input string what, input fir_res_t want);
        err_count++;
        if (err_count <= 10)
            $display("mismatch (%s): expected %0d sat %0b last %0b, got %0d sat %0b last %0b",
                     what, $signed(want.sample), want.sat, want.last,
                     $signed(m_tdata), m_tuser, m_tlast);
    endtask

    always @(posedge aclk) begin : monitor
        int       base;
        fir_res_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == REG_TAP_COUNT)
                taps_reg = pwdata[CFG_W-1:0];
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_LOAD) begin
                    coef_taps[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: SAMPLE_W];
                end else begin
                    base = conv_q.size();
                    predict_sample(s_tdata[IDX_W +: SAMPLE_W], s_tlast);
                    if (word_chk) conv_q[base] = word_res;
                end
            end
            if (m_tvalid && m_tready) begin
                if (conv_q.size() == 0) begin
                    flag_mismatch("unexpected word", '0);
                end else begin
                    want = conv_q.pop_front();
                    if (m_tdata != want.sample || m_tuser != want.sat || m_tlast != want.last)
                        flag_mismatch("field", want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[fir_convolution_with_tail_unit] ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] val, input logic last,
                             input logic chk, input fir_res_t res);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {{(S_TDATA_W - IDX_W - SAMPLE_W){1'b0}}, val, idx};
        word_chk <= chk;
        word_res <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (conv_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_taps(input logic [CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TAP_COUNT;
        pwdata  <= APB_DW'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_q15();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return SAMPLE_W'($urandom);
            default: return SAMPLE_W'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    initial begin
        int               m;
        int               frame_left;
        logic [CFG_W-1:0] tc;
        logic [IDX_W-1:0] idx;
        for (int i = 0; i < TAPS; i++) begin
            delay_taps[i] = '0;
            coef_taps[i]  = '0;
        end
        taps_reg = TAP_COUNT_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].op == OP_TAPS) begin
                wait_idle();
                write_taps(dir_steps[i].val[CFG_W-1:0]);
            end else begin
                send_word(dir_steps[i].op == OP_SAMPLE ? KIND_SAMPLE : KIND_LOAD,
                          dir_steps[i].idx, dir_steps[i].val, dir_steps[i].last,
                          dir_steps[i].chk, dir_steps[i].res);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       tc = 7'd64;
                1:       tc = 7'd1;
                2:       tc = 7'd0;
                3:       tc = 7'd127;
                4:       tc = CFG_W'($urandom_range(2, 8));
                5:       tc = CFG_W'($urandom_range(9, 32));
                6:       tc = 7'd3;
                default: tc = CFG_W'($urandom_range(0, 127));
            endcase
            wait_idle();
            write_taps(tc);
            tx_idle_pct  = tx_mode[p % 4];
            rx_stall_pct = rx_mode[p % 4];
            m            = taps_eff(tc);
            frame_left   = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) < 25) begin
                    if ($urandom_range(0, 9) < 7) idx = IDX_W'($urandom_range(0, m - 1));
                    else                          idx = IDX_W'($urandom);
                    send_word(KIND_LOAD, idx, rand_q15(), 1'($urandom), 1'b0, '0);
                end else begin
                    if (frame_left == 0) frame_left = $urandom_range(1, 10);
                    frame_left--;
                    send_word(KIND_SAMPLE, IDX_W'($urandom), rand_q15(), frame_left == 0,
                              1'b0, '0);
                end
            end
        end

        wait_idle();
        if (err_count == 0 && conv_q.size() == 0)
            $display("[fir_convolution_with_tail_unit] OK");
        else
            $display("[fir_convolution_with_tail_unit] ERROR");
        $finish;
    end

endmodule
